// ===== sv/iccf_pkg.sv =====
`timescale 1ns / 1ps
package iccf_pkg;

  localparam logic [7:0]  DOLLAR_CHAR      = 8'h24;
  localparam int          RunMax           = 4;
  localparam int          CountW           = 3;
  localparam logic [11:0] BASE_COLOUR_RST  = 12'hFFF;

  typedef logic [1:0] phase_t;

  typedef struct packed {
    logic [RunMax-1:0][7:0] chars;
    logic [CountW-1:0]      count;
    logic                   char_valid;
    logic [11:0]            colour;
    logic                   uses_base;
    logic                   done;
  } run_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) begin
      return c[3:0];
    end else if (is_hex(c)) begin
      return c[3:0] + 4'd9;
    end else begin
      return 4'd0;
    end
  endfunction

endpackage

// ===== sv/iccf_decode.sv =====
`timescale 1ns / 1ps
module iccf_decode import iccf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        take_i,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_text_i,
  input  logic [11:0] base_colour_i,
  output run_t        run_o
);

  phase_t        phase_q, phase_d;
  logic [11:0]   colour_q, colour_d;
  logic          is_base_q, is_base_d;
  logic [1:0][7:0] held_q;
  logic          held_we;
  logic [RunMax-1:0][7:0] list;
  logic          is_dollar;
  logic          pend_hex;
  logic [CountW-1:0] phase_ext;
  logic [CountW-1:0] count;

  always_comb begin
    is_dollar = (text_byte_i == DOLLAR_CHAR);
    pend_hex  = (phase_q != 2'd0) && is_hex(text_byte_i) && !is_dollar;
    phase_ext = CountW'(phase_q);

    list[0] = DOLLAR_CHAR;
    list[1] = held_q[0];
    list[2] = held_q[1];
    list[3] = text_byte_i;
    list[phase_q] = text_byte_i;

    phase_d   = phase_q;
    colour_d  = colour_q;
    is_base_d = is_base_q;
    held_we   = 1'b0;

    priority if (is_dollar) begin
      count   = phase_ext + CountW'(end_of_text_i);
      phase_d = 2'd1;
    end else if (pend_hex && phase_q == 2'd3) begin
      count     = '0;
      phase_d   = 2'd0;
      colour_d  = {hex_value(held_q[0]), hex_value(held_q[1]), hex_value(text_byte_i)};
      is_base_d = 1'b0;
    end else if (pend_hex) begin
      count   = end_of_text_i ? phase_ext + CountW'(1) : '0;
      phase_d = phase_q + 2'd1;
      held_we = 1'b1;
    end else begin
      count   = phase_ext + CountW'(1);
      phase_d = 2'd0;
    end

    if (end_of_text_i) begin
      phase_d   = 2'd0;
      colour_d  = '0;
      is_base_d = 1'b1;
    end

    run_o.chars      = list;
    run_o.done       = end_of_text_i;
    run_o.char_valid = 1'b1;
    run_o.uses_base  = is_base_q;
    run_o.colour     = is_base_q ? base_colour_i : colour_q;
    run_o.count      = count;
    if (end_of_text_i && count == '0) begin
      run_o.count      = CountW'(1);
      run_o.char_valid = 1'b0;
      run_o.uses_base  = 1'b0;
      run_o.colour     = '0;
      run_o.chars      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= 2'd0;
      colour_q  <= '0;
      is_base_q <= 1'b1;
    end else if (take_i) begin
      phase_q   <= phase_d;
      colour_q  <= colour_d;
      is_base_q <= is_base_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && held_we) begin
      held_q[phase_q[1]] <= text_byte_i;
    end
  end

endmodule

// ===== sv/iccf_emit.sv =====
`timescale 1ns / 1ps
module iccf_emit import iccf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  run_t        run_i,
  output logic        ready_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_char_o,
  output logic        char_valid_o,
  output logic [3:0]  red_level_o,
  output logic [3:0]  green_level_o,
  output logic [3:0]  blue_level_o,
  output logic        uses_base_o,
  output logic        text_done_o,
  output logic        last_of_run_o
);

  logic [RunMax-1:0][7:0] chars_q;
  logic [CountW-1:0] rem_q;
  logic [1:0]        idx_q;
  logic              char_valid_q;
  logic [11:0]       colour_q;
  logic              uses_base_q;
  logic              done_q;
  logic              out_valid_q;
  logic [7:0]        out_char_q;
  logic              out_cv_q;
  logic [11:0]       out_colour_q;
  logic              out_base_q;
  logic              out_done_q;
  logic              out_last_q;
  logic              pop;
  logic              last_pop;

  assign pop      = (rem_q != '0) && (!out_valid_q || !out_stall_i);
  assign last_pop = (rem_q == CountW'(1));
  assign ready_o  = (rem_q == '0) || (last_pop && pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_i && ready_o) begin
        rem_q <= run_i.count;
        idx_q <= 2'd0;
      end else if (pop) begin
        rem_q <= rem_q - CountW'(1);
        idx_q <= idx_q + 2'd1;
      end
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && ready_o) begin
      chars_q      <= run_i.chars;
      char_valid_q <= run_i.char_valid;
      colour_q     <= run_i.colour;
      uses_base_q  <= run_i.uses_base;
      done_q       <= run_i.done;
    end
    if (pop) begin
      out_char_q   <= chars_q[idx_q];
      out_cv_q     <= char_valid_q;
      out_colour_q <= colour_q;
      out_base_q   <= uses_base_q;
      out_done_q   <= done_q && last_pop;
      out_last_q   <= last_pop;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_char_o    = out_char_q;
  assign char_valid_o  = out_cv_q;
  assign red_level_o   = out_colour_q[11:8];
  assign green_level_o = out_colour_q[7:4];
  assign blue_level_o  = out_colour_q[3:0];
  assign uses_base_o   = out_base_q;
  assign text_done_o   = out_done_q;
  assign last_of_run_o = out_last_q;

endmodule

// ===== sv/inline_colour_code_filter.sv =====
`timescale 1ns / 1ps
// Strips '$RGB' colour codes from a byte stream and tags each remaining
// character with its colour nibbles (or the base colour). Bytes enter an
// input register, are decoded in one pass against the match state, and the
// resulting run of zero to four words is played out through an output
// register one word per clock while the output is not stalled. A byte that
// yields zero or one word does not hold the input, so plain text then flows at
// one byte per clock; a byte that yields more (a broken or flushed code) holds
// the input until its last word pops into the output register.
module inline_colour_code_filter import iccf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_char_o,
  output logic        char_valid_o,
  output logic [3:0]  red_level_o,
  output logic [3:0]  green_level_o,
  output logic [3:0]  blue_level_o,
  output logic        uses_base_o,
  output logic        text_done_o,
  output logic        last_of_run_o
);

  logic [11:0] base_colour_q;
  logic        in_valid_q;
  logic [7:0]  byte_q;
  logic        eot_q;
  logic        emit_ready;
  logic        consume;
  run_t        run;

  assign consume    = in_valid_q && emit_ready;
  assign in_stall_o = in_valid_q && !emit_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_colour_q <= BASE_COLOUR_RST;
      in_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        base_colour_q <= cfg_wdata_i;
      end
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= text_byte_i;
      eot_q  <= end_of_text_i;
    end
  end

  iccf_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (consume),
    .text_byte_i   (byte_q),
    .end_of_text_i (eot_q),
    .base_colour_i (base_colour_q),
    .run_o         (run)
  );

  iccf_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (consume),
    .run_i         (run),
    .ready_o       (emit_ready),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_char_o    (out_char_o),
    .char_valid_o  (char_valid_o),
    .red_level_o   (red_level_o),
    .green_level_o (green_level_o),
    .blue_level_o  (blue_level_o),
    .uses_base_o   (uses_base_o),
    .text_done_o   (text_done_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// ===== sv/iccf_checker.sv =====
`timescale 1ns / 1ps
module iccf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  out_char_o,
  input logic        char_valid_o,
  input logic [3:0]  red_level_o,
  input logic [3:0]  green_level_o,
  input logic [3:0]  blue_level_o,
  input logic        uses_base_o,
  input logic        text_done_o,
  input logic        last_of_run_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_char_o) && $stable(last_of_run_o) &&
      $stable(text_done_o))
    else $error("stalled output word changed");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && text_done_o |-> last_of_run_o)
    else $error("end of text not on last word of run");

  a_bare_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !char_valid_o |-> text_done_o && !uses_base_o &&
      red_level_o == 4'd0 && green_level_o == 4'd0 && blue_level_o == 4'd0 &&
      out_char_o == 8'd0)
    else $error("bare end marker malformed");

endmodule

bind inline_colour_code_filter iccf_checker u_iccf_checker (.*);

// ===== dv/inline_colour_code_filter_tb.sv =====
`timescale 1ns / 1ps
module inline_colour_code_filter_tb;
  import iccf_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 60;

  localparam phase_t PH_IDLE   = 2'd0;
  localparam phase_t PH_DOLLAR = 2'd1;
  localparam phase_t PH_ONE    = 2'd2;
  localparam phase_t PH_TWO    = 2'd3;

  typedef struct packed {
    logic [7:0] chr;
    logic       has_char;
    logic [3:0] red;
    logic [3:0] green;
    logic [3:0] blue;
    logic       base;
    logic       done;
    logic       last;
  } word_t;

  typedef struct packed {
    logic [7:0] chr;
    logic       eot;
    logic       typed;
    word_t      w;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [11:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  text_byte_i = '0;
  logic        end_of_text_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  out_char_o;
  logic        char_valid_o;
  logic [3:0]  red_level_o;
  logic [3:0]  green_level_o;
  logic [3:0]  blue_level_o;
  logic        uses_base_o;
  logic        text_done_o;
  logic        last_of_run_o;

  inline_colour_code_filter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_char_o    (out_char_o),
    .char_valid_o  (char_valid_o),
    .red_level_o   (red_level_o),
    .green_level_o (green_level_o),
    .blue_level_o  (blue_level_o),
    .uses_base_o   (uses_base_o),
    .text_done_o   (text_done_o),
    .last_of_run_o (last_of_run_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // colour tracker state
  logic [11:0] base_reg = BASE_COLOUR_RST;
  phase_t      match_st = PH_IDLE;
  logic [7:0]  held_hex [2];
  logic [11:0] cur_colour = '0;
  logic        at_base = 1'b1;
  word_t       run_q[$];
  word_t       expected_q[$];

  int unsigned bytes_sent;
  int unsigned words_seen;
  int unsigned codes_taken;
  int unsigned strings_ended;
  int unsigned settings_used;
  int unsigned mismatches;
  int unsigned idle_cycles;

  bit          tx_quiet;
  bit          tx_burst;
  int unsigned tx_left;
  bit          rx_hold_req;

  stim_row_t dir_rows [24] = '{
    '{8'h41, 1'b0, 1'b1, '{8'h41, 1'b1, 4'hF, 4'hF, 4'hF, 1'b1, 1'b0, 1'b1}},
    '{8'hFF, 1'b0, 1'b1, '{8'hFF, 1'b1, 4'hF, 4'hF, 4'hF, 1'b1, 1'b0, 1'b1}},
    '{8'h01, 1'b1, 1'b1, '{8'h01, 1'b1, 4'hF, 4'hF, 4'hF, 1'b1, 1'b1, 1'b1}},
    '{8'h24, 1'b0, 1'b0, '0},
    '{8'h31, 1'b0, 1'b0, '0},
    '{8'h61, 1'b0, 1'b0, '0},
    '{8'h46, 1'b0, 1'b0, '0},
    '{8'h47, 1'b0, 1'b0, '0},
    '{8'h24, 1'b0, 1'b0, '0},
    '{8'h39, 1'b0, 1'b0, '0},
    '{8'h24, 1'b0, 1'b0, '0},
    '{8'h62, 1'b0, 1'b0, '0},
    '{8'h43, 1'b0, 1'b0, '0},
    '{8'h67, 1'b0, 1'b0, '0},
    '{8'h24, 1'b0, 1'b0, '0},
    '{8'h30, 1'b0, 1'b0, '0},
    '{8'h66, 1'b0, 1'b0, '0},
    '{8'h45, 1'b1, 1'b1, '{8'h00, 1'b0, 4'h0, 4'h0, 4'h0, 1'b0, 1'b1, 1'b1}},
    '{8'h24, 1'b1, 1'b1, '{8'h24, 1'b1, 4'hF, 4'hF, 4'hF, 1'b1, 1'b1, 1'b1}},
    '{8'h3A, 1'b0, 1'b0, '0},
    '{8'h24, 1'b0, 1'b0, '0},
    '{8'h44, 1'b0, 1'b0, '0},
    '{8'h37, 1'b1, 1'b0, '0},
    '{8'h80, 1'b1, 1'b1, '{8'h80, 1'b1, 4'hF, 4'hF, 4'hF, 1'b1, 1'b1, 1'b1}}
  };

  function automatic logic is_hex_digit(input logic [7:0] c);
    logic [7:0] lc;
    lc = c | 8'h20;
    return (c >= 8'h30 && c <= 8'h39) || (lc >= 8'h61 && lc <= 8'h66);
  endfunction

  function automatic logic [3:0] digit_nibble(input logic [7:0] c);
    logic [7:0] lc;
    lc = c | 8'h20;
    if (c <= 8'h39) begin
      return c[3:0];
    end
    return 4'(lc - 8'h57);
  endfunction

  function automatic void emit_char(input logic [7:0] c);
    logic [11:0] col;
    word_t       w;
    col = at_base ? base_reg : cur_colour;
    w = '{c, 1'b1, col[11:8], col[7:4], col[3:0], at_base, 1'b0, 1'b0};
    run_q = {run_q, w};
  endfunction

  function automatic void release_held();
    if (match_st == PH_IDLE) begin
      return;
    end
    emit_char(DOLLAR_CHAR);
    if (match_st == PH_ONE || match_st == PH_TWO) begin
      emit_char(held_hex[0]);
    end
    if (match_st == PH_TWO) begin
      emit_char(held_hex[1]);
    end
    match_st = PH_IDLE;
  endfunction

  function automatic void predict_run(input logic [7:0] c, input logic eot);
    word_t w;
    run_q.delete();
    if (c == DOLLAR_CHAR) begin
      release_held();
      match_st = PH_DOLLAR;
    end else if (match_st != PH_IDLE && is_hex_digit(c)) begin
      if (match_st == PH_TWO) begin
        cur_colour = {digit_nibble(held_hex[0]), digit_nibble(held_hex[1]), digit_nibble(c)};
        at_base = 1'b0;
        match_st = PH_IDLE;
        codes_taken++;
      end else begin
        held_hex[(match_st == PH_DOLLAR) ? 0 : 1] = c;
        match_st = match_st + 2'd1;
      end
    end else begin
      release_held();
      emit_char(c);
    end
    if (eot) begin
      release_held();
      if (run_q.size() == 0) begin
        w = '0;
        run_q = {run_q, w};
      end
      w = run_q.pop_back();
      w.done = 1'b1;
      run_q = {run_q, w};
      match_st = PH_IDLE;
      cur_colour = '0;
      at_base = 1'b1;
      strings_ended++;
    end
    if (run_q.size() != 0) begin
      w = run_q.pop_back();
      w.last = 1'b1;
      run_q = {run_q, w};
    end
  endfunction

  function automatic logic [7:0] rand_text(input bit allow_hex);
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(1, 255));
    end while (c == DOLLAR_CHAR || (!allow_hex && is_hex_digit(c)));
    return c;
  endfunction

  function automatic logic [7:0] rand_hex();
    int unsigned v;
    v = $urandom_range(0, 15);
    if (v < 10) begin
      return 8'(8'h30 + v);
    end
    return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 10);
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic eot, input logic typed,
                           input word_t tw);
    int unsigned gap;
    if (tx_left == 0) begin
      tx_quiet = ($urandom_range(0, 3) == 0);
      tx_left = $urandom_range(8, 24);
    end
    tx_left--;
    gap = (tx_quiet || tx_burst) ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    text_byte_i <= c;
    end_of_text_i <= eot;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    predict_run(c, eot);
    if (typed) begin
      expected_q = {expected_q, tw};
    end else begin
      expected_q = {expected_q, run_q};
    end
    bytes_sent++;
  endtask

  task automatic send_text(input int unsigned n);
    int unsigned sent;
    int unsigned kind;
    logic [7:0]  seg[$];
    sent = 0;
    while (sent < n) begin
      seg.delete();
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3: begin
          repeat ($urandom_range(1, 4)) seg = {seg, rand_text(1'b1)};
        end
        4, 5, 6: begin
          seg = {seg, DOLLAR_CHAR};
          repeat (3) seg = {seg, rand_hex()};
        end
        7: begin
          seg = {seg, DOLLAR_CHAR};
          repeat ($urandom_range(0, 2)) seg = {seg, rand_hex()};
          seg = {seg, (($urandom_range(0, 2) == 0) ? DOLLAR_CHAR : rand_text(1'b0))};
        end
        default: begin
          seg = {seg, 8'($urandom_range(1, 255))};
        end
      endcase
      foreach (seg[k]) send_byte(seg[k], ($urandom_range(0, 11) == 0), 1'b0, '0);
      sent += seg.size();
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_base(input logic [11:0] v);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    base_reg = v;
    settings_used++;
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_base(BASE_COLOUR_RST);
    foreach (dir_rows[r]) begin
      send_byte(dir_rows[r].chr, dir_rows[r].eot, dir_rows[r].typed, dir_rows[r].w);
    end
    write_base(12'h000);
    send_text(60);
    // hold the receiver off while words keep coming in
    rx_hold_req = 1'b1;
    tx_burst = 1'b1;
    send_text(30);
    tx_burst = 1'b0;
    write_base(12'($urandom_range(1, 4094)));
    send_text(40);
    wait_drained();
    send_text(30);
    write_base(12'($urandom_range(0, 4095)));
    send_text(30);
    wait_drained();
    $display("run covered %0d bytes, %0d words, %0d base colour settings",
             bytes_sent, words_seen, settings_used);
    $display("%0d colour codes taken, %0d strings ended, %0d mismatches",
             codes_taken, strings_ended, mismatches);
    if (mismatches == 0) begin
      $display("** inline_colour_code_filter: PASSED **");
    end else begin
      $display("** inline_colour_code_filter: FAILED **");
    end
    $finish;
  end

  initial begin : rx_side
    int unsigned pause;
    int unsigned rx_left;
    bit          rx_quiet;
    rx_left = 0;
    rx_quiet = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (rx_left == 0) begin
        rx_quiet = ($urandom_range(0, 3) == 0);
        rx_left = $urandom_range(8, 24);
      end
      rx_left--;
      pause = rx_quiet ? 0 : $urandom_range(0, 6);
      if (rx_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end
      if (pause != 0) begin
        out_stall_i <= 1'b1;
        repeat (pause) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(negedge clk_i); while (!out_valid_o);
      @(posedge clk_i);
    end
  end

  always @(negedge clk_i) begin : word_check
    word_t got;
    word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{out_char_o, char_valid_o, red_level_o, green_level_o, blue_level_o,
              uses_base_o, text_done_o, last_of_run_o};
      words_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected word char=%h valid=%b rgb=%h%h%h base=%b done=%b last=%b",
                   $realtime, got.chr, got.has_char, got.red, got.green, got.blue,
                   got.base, got.done, got.last);
        end
      end else begin
        want = expected_q.pop_front();
        if (got.chr !== want.chr || got.has_char !== want.has_char ||
            got.red !== want.red || got.green !== want.green ||
            got.blue !== want.blue || got.base !== want.base ||
            got.done !== want.done || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: word %0d expected char=%h valid=%b rgb=%h%h%h base=%b done=%b last=%b",
                     $realtime, words_seen, want.chr, want.has_char, want.red, want.green,
                     want.blue, want.base, want.done, want.last);
            $display("  got char=%h valid=%b rgb=%h%h%h base=%b done=%b last=%b",
                     got.chr, got.has_char, got.red, got.green, got.blue, got.base,
                     got.done, got.last);
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: %0d cycles without a handshake, %0d words outstanding",
                 idle_cycles, expected_q.size());
        $display("** inline_colour_code_filter: FAILED **");
        $finish;
      end
    end
  end

endmodule

// ===== sim.f =====
sv/iccf_pkg.sv
sv/iccf_decode.sv
sv/iccf_emit.sv
sv/inline_colour_code_filter.sv
sv/iccf_checker.sv
dv/inline_colour_code_filter_tb.sv
